FILE: hdl/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
package wsd_pkg;

	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_PONG    = 2'd1,
		KIND_CLOSE   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
	} res_t;

endpackage

FILE: hdl/websocket_frame_deframer_core.sv
// top level of the websocket frame deframer
// Receive-side WebSocket frame parser. Bytes of the framed stream enter on
// the in channel (in_valid/in_ready/in_byte), one per transaction. Header
// bytes (FIN/opcode, mask bit and length, extended length, masking key)
// are absorbed without a result. Each payload byte leaves on the out
// channel as kind 0 with the key applied when the frame is masked, and
// last_of_frame marks the final byte. A ping header gives a kind 1 result,
// a close header gives a kind 2 result and the parser then ignores all
// bytes until reset.
// Results are registered in the output stage as their input bytes are
// accepted, one byte per cycle while in_ready is high; the parser state
// update and result are combinational from the state registers and byte.
// When the receiver stalls, a result register plus one skid entry keep
// in_ready high until two results are waiting; then in_ready drops until
// the receiver takes one. Reset clears the parser to expect a new header
// and empties both output entries. LENGTH_BITS sets the payload length
// counter width; longer extended lengths saturate.
module websocket_frame_deframer_core #(
	parameter int LENGTH_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode_out,
	output logic       frame_fin_out,
	output logic       last_of_frame
);
	import wsd_pkg::*;

	logic accept;
	logic res_valid;
	res_t res, out_res;

	assign accept = in_valid && in_ready;

	wsd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_res  (res),
		.ready     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind             = out_res.kind;
	assign payload_byte     = out_res.payload_byte;
	assign frame_opcode_out = out_res.opcode;
	assign frame_fin_out    = out_res.fin;
	assign last_of_frame    = out_res.last;

endmodule

FILE: hdl/wsd_parser.sv
// frame header parser, length counter and payload unmasking
module wsd_parser #(
	parameter int LENGTH_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    in_byte,
	output logic          res_valid,
	output wsd_pkg::res_t res
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT     = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_HALT    = 3'd5
	} phase_t;

	phase_t                   phase_q, phase_n;
	logic [3:0]               ext_left_q, ext_left_n;
	logic [2:0]               key_left_q, key_left_n;
	logic                     fin_q, fin_n;
	logic [3:0]               opcode_q, opcode_n;
	logic                     masked_q, masked_n;
	logic [31:0]              key_q, key_n;
	logic [LENGTH_BITS-1:0]   rem_q, rem_n;
	logic [1:0]               pos_q, pos_n;

	logic       len_done, hdr_done;
	logic [6:0] len7;
	logic [7:0] kb;

	always_comb begin
		phase_n    = phase_q;
		ext_left_n = ext_left_q;
		key_left_n = key_left_q;
		fin_n      = fin_q;
		opcode_n   = opcode_q;
		masked_n   = masked_q;
		key_n      = key_q;
		rem_n      = rem_q;
		pos_n      = pos_q;
		len_done   = 1'b0;
		hdr_done   = 1'b0;
		len7       = in_byte[6:0];
		kb         = 8'd0;
		res_valid  = 1'b0;
		res.kind         = KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.opcode       = opcode_q;
		res.fin          = fin_q;
		res.last         = 1'b0;

		unique case (pos_q)
			2'd0: kb = key_q[31:24];
			2'd1: kb = key_q[23:16];
			2'd2: kb = key_q[15:8];
			2'd3: kb = key_q[7:0];
			default: kb = 8'd0;
		endcase
		if (!masked_q) begin
			kb = 8'd0;
		end

		unique case (phase_q)
			PH_HDR0: begin
				fin_n    = in_byte[7];
				opcode_n = in_byte[3:0];
				phase_n  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_n = in_byte[7];
				rem_n    = '0;
				if (len7 == LEN7_EXT16) begin
					ext_left_n = EXT16_BYTES;
					phase_n    = PH_EXT;
				end else if (len7 == LEN7_EXT64) begin
					ext_left_n = EXT64_BYTES;
					phase_n    = PH_EXT;
				end else begin
					rem_n    = {{(LENGTH_BITS-7){1'b0}}, len7};
					len_done = 1'b1;
				end
			end
			PH_EXT: begin
				// saturate when the next shift would push bits out
				if (rem_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
					rem_n = '1;
				end else begin
					rem_n = {rem_q[LENGTH_BITS-9:0], in_byte};
				end
				ext_left_n = ext_left_q - 4'd1;
				len_done   = (ext_left_n == 4'd0);
			end
			PH_KEY: begin
				key_n      = {key_q[23:0], in_byte};
				key_left_n = key_left_q - 3'd1;
				hdr_done   = (key_left_n == 3'd0);
			end
			PH_PAYLOAD: begin
				pos_n            = pos_q + 2'd1;
				rem_n            = rem_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
				res_valid        = 1'b1;
				res.payload_byte = in_byte ^ kb;
				if (rem_n == '0) begin
					phase_n  = PH_HDR0;
					res.last = 1'b1;
				end
			end
			default: begin
				// halted after a close header
			end
		endcase

		if (len_done) begin
			if (masked_n) begin
				key_left_n = KEY_BYTES;
				phase_n    = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			pos_n = 2'd0;
			if (opcode_q == OP_CLOSE) begin
				phase_n   = PH_HALT;
				res_valid = 1'b1;
				res.kind  = KIND_CLOSE;
			end else begin
				phase_n = (rem_n == '0) ? PH_HDR0 : PH_PAYLOAD;
				if (opcode_q == OP_PING) begin
					res_valid = 1'b1;
					res.kind  = KIND_PONG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			ext_left_q <= 4'd0;
			key_left_q <= 3'd0;
			fin_q      <= 1'b0;
			opcode_q   <= 4'd0;
			masked_q   <= 1'b0;
			key_q      <= 32'd0;
			rem_q      <= '0;
			pos_q      <= 2'd0;
		end else if (push) begin
			phase_q    <= phase_n;
			ext_left_q <= ext_left_n;
			key_left_q <= key_left_n;
			fin_q      <= fin_n;
			opcode_q   <= opcode_n;
			masked_q   <= masked_n;
			key_q      <= key_n;
			rem_q      <= rem_n;
			pos_q      <= pos_n;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt without reset");

	a_close_halts: assert property (@(posedge clk) disable iff (!arst_n)
		push && res_valid && res.kind == KIND_CLOSE |=> phase_q == PH_HALT)
		else $error("close event did not halt parser");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero bytes due");

endmodule

FILE: hdl/wsd_out_stage.sv
// result register with skid entry so input keeps flowing under stall
module wsd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wsd_pkg::res_t push_res,
	output logic          ready,
	output logic          out_valid,
	input  logic          out_ready,
	output wsd_pkg::res_t out_res
);
	import wsd_pkg::*;

	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop       = main_v_q && out_ready;
	assign ready     = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held without a main entry");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && pop |=> main_v_q && !skid_v_q)
		else $error("skid entry not promoted after transaction");

endmodule

FILE: tb/sv/tb_websocket_frame_deframer_core.sv
// testbench of the websocket frame deframer core with a byte-level parser scoreboard
module tb_websocket_frame_deframer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int LEN_W        = 64;
	localparam int RANDOM_BYTES = 1800;
	localparam int LIMIT_CYCLES = 600000;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_PAYLOAD, PH_HALT
	} parse_phase_t;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	class frame_scoreboard;
		parse_phase_t       phase;
		logic [3:0]         ext_left;
		logic [2:0]         key_left;
		logic               fin;
		logic [3:0]         opc;
		logic               masked;
		logic [31:0]        key;
		logic [LEN_W-1:0]   remaining;
		logic [1:0]         pos;
		res_t               due_results[$];
		int                 mismatches;
		int                 checked;
		int                 pongs;
		int                 closes;
		int                 frame_ends;

		function new();
			phase = PH_HDR0;
			ext_left = '0;
			key_left = '0;
			fin = 1'b0;
			opc = '0;
			masked = 1'b0;
			key = '0;
			remaining = '0;
			pos = '0;
			mismatches = 0;
			checked = 0;
			pongs = 0;
			closes = 0;
			frame_ends = 0;
		endfunction

		function void push_result(kind_t k, logic [7:0] d, logic lst);
			res_t r;
			r.kind = k;
			r.payload_byte = d;
			r.opcode = opc;
			r.fin = fin;
			r.last = lst;
			due_results.push_back(r);
		endfunction

		function void header_complete();
			pos = '0;
			if (opc == OP_CLOSE) begin
				phase = PH_HALT;
				push_result(KIND_CLOSE, 8'h00, 1'b0);
			end else begin
				phase = (remaining == '0) ? PH_HDR0 : PH_PAYLOAD;
				if (opc == OP_PING)
					push_result(KIND_PONG, 8'h00, 1'b0);
			end
		endfunction

		function void length_known();
			if (masked) begin
				key_left = KEY_BYTES;
				phase = PH_KEY;
			end else begin
				header_complete();
			end
		endfunction

		function bit halted();
			return phase == PH_HALT;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void note_input(logic [7:0] b);
			logic [7:0] kb;
			logic [6:0] len7;
			case (phase)
				PH_HDR0: begin
					fin = b[7];
					opc = b[3:0];
					phase = PH_HDR1;
				end
				PH_HDR1: begin
					masked = b[7];
					len7 = b[6:0];
					remaining = '0;
					if (len7 == LEN7_EXT16) begin
						ext_left = EXT16_BYTES;
						phase = PH_EXT;
					end else if (len7 == LEN7_EXT64) begin
						ext_left = EXT64_BYTES;
						phase = PH_EXT;
					end else begin
						remaining = LEN_W'(len7);
						length_known();
					end
				end
				PH_EXT: begin
					// a length too wide for the counter pins it at all ones
					if ((remaining >> (LEN_W - 8)) != '0)
						remaining = '1;
					else
						remaining = {remaining[LEN_W-9:0], b};
					ext_left = ext_left - 4'd1;
					if (ext_left == '0)
						length_known();
				end
				PH_KEY: begin
					key = {key[23:0], b};
					key_left = key_left - 3'd1;
					if (key_left == '0)
						header_complete();
				end
				PH_PAYLOAD: begin
					kb = masked ? key[8*(3-pos) +: 8] : 8'h00;
					pos = pos + 2'd1;
					remaining = remaining - 1'b1;
					if (remaining == '0) begin
						phase = PH_HDR0;
						push_result(KIND_PAYLOAD, b ^ kb, 1'b1);
					end else begin
						push_result(KIND_PAYLOAD, b ^ kb, 1'b0);
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none actual kind %0d byte %0d",
					$time, got.kind, got.payload_byte);
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare_field("kind", want.kind, got.kind);
			compare_field("payload_byte", want.payload_byte, got.payload_byte);
			compare_field("frame_opcode_out", want.opcode, got.opcode);
			compare_field("frame_fin_out", want.fin, got.fin);
			compare_field("last_of_frame", want.last, got.last);
			if (want.kind == KIND_PONG)
				pongs++;
			if (want.kind == KIND_CLOSE)
				closes++;
			if (want.kind == KIND_PAYLOAD && want.last)
				frame_ends++;
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode_out;
	logic       frame_fin_out;
	logic       last_of_frame;

	frame_scoreboard sb = new();
	int  bytes_parsed;
	int  cycles;
	bit  quiet_sender;

	websocket_frame_deframer_core #(.LENGTH_BITS(LEN_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.frame_opcode_out(frame_opcode_out),
		.frame_fin_out(frame_fin_out),
		.last_of_frame(last_of_frame)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(res_t'{kind_t'(kind), payload_byte, frame_opcode_out,
				frame_fin_out, last_of_frame});
	end

	// receiver: stretches of always ready, light stalls and heavy stalls
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 9) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (!sb.halted())
			bytes_parsed++;
		sb.note_input(b);
	endtask

	// fill below zero gives random payload, otherwise a constant byte
	task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
			input logic masked, input len_form_t form, input logic [63:0] len,
			input logic [31:0] key, input int fill);
		longint unsigned n;
		push_byte({fin, rsv, op});
		case (form)
			LEN_SHORT: push_byte({masked, len[6:0]});
			LEN_EXT16: begin
				push_byte({masked, LEN7_EXT16});
				for (int i = 1; i >= 0; i--)
					push_byte(len[8*i +: 8]);
			end
			default: begin
				push_byte({masked, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					push_byte(len[8*i +: 8]);
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				push_byte(key[8*i +: 8]);
		for (n = 0; n < len; n++)
			push_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
	endtask

	task automatic send_random_frame();
		logic [3:0] op;
		logic [63:0] len;
		len_form_t form;
		int r;
		quiet_sender = ($urandom_range(0, 4) == 0);
		op = 4'($urandom);
		if ($urandom_range(0, 6) == 0)
			op = OP_PING;
		if (op == OP_CLOSE)
			op = OP_BINARY;
		r = $urandom_range(0, 99);
		form = LEN_SHORT;
		if (r < 10) begin
			len = 0;
		end else if (r < 65) begin
			len = $urandom_range(1, 12);
		end else if (r < 78) begin
			len = $urandom_range(13, 125);
		end else if (r < 89) begin
			form = LEN_EXT16;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(126, 300);
		end else begin
			form = LEN_EXT64;
			len = $urandom_range(0, 300);
		end
		send_frame(1'($urandom), 3'($urandom), op, 1'($urandom), form, len, $urandom, -1);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		cycles <= 0;
		bytes_parsed = 0;
		quiet_sender = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte text, ping carrying a byte, 16-bit length with all-ones key,
		// empty frame with 64-bit length
		send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_SHORT, 64'd1, 32'h0, 8'h00);
		send_frame(1'b1, 3'b000, OP_PING, 1'b0, LEN_SHORT, 64'd1, 32'h0, 8'hFF);
		send_frame(1'b0, 3'b111, OP_BINARY, 1'b1, LEN_EXT16, 64'd2, 32'hFFFF_FFFF, 8'h00);
		send_frame(1'b1, 3'b000, OP_CONT, 1'b0, LEN_EXT64, 64'd0, 32'h0, 8'h00);

		while (bytes_parsed < RANDOM_BYTES)
			send_random_frame();

		// close halts the parser, so it goes last; its payload and the rest are ignored
		quiet_sender = 1'b0;
		send_frame(1'b1, 3'b000, OP_CLOSE, 1'b1, LEN_SHORT, 64'd2, $urandom, -1);
		repeat (6)
			push_byte(8'($urandom));
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("parsed %0d bytes; %0d results checked: %0d frame ends, %0d pongs, %0d close",
			bytes_parsed, sb.checked, sb.frame_ends, sb.pongs, sb.closes);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
